// ===== sv/text_case_converter_macros.svh =====
// assertion macros used by the checker file of the case converter
`ifndef TEXT_CASE_CONVERTER_MACROS_SVH
`define TEXT_CASE_CONVERTER_MACROS_SVH

// same-cycle implication, checked outside the given disable condition
`define TCC_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside the given disable condition
`define TCC_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/tcc_pkg.sv =====
// shared types, codes and character helpers of the case converter
package tcc_pkg;

   // queue between front and back
   localparam int QueueDepth = 2;

   // case mode codes
   localparam logic [4:0] ModePass       = 5'd0;
   localparam logic [4:0] ModeCamel      = 5'd1;
   localparam logic [4:0] ModeCapital    = 5'd2;
   localparam logic [4:0] ModeConstant   = 5'd3;
   localparam logic [4:0] ModeDot        = 5'd4;
   localparam logic [4:0] ModeHeader     = 5'd5;
   localparam logic [4:0] ModeNo         = 5'd6;
   localparam logic [4:0] ModeParam      = 5'd7;
   localparam logic [4:0] ModePascal     = 5'd8;
   localparam logic [4:0] ModePath       = 5'd9;
   localparam logic [4:0] ModeSentence   = 5'd10;
   localparam logic [4:0] ModeSnake      = 5'd11;
   localparam logic [4:0] ModeTitle      = 5'd12;
   localparam logic [4:0] ModeSwap       = 5'd13;
   localparam logic [4:0] ModeLower      = 5'd14;
   localparam logic [4:0] ModeLowerFirst = 5'd15;
   localparam logic [4:0] ModeUpper      = 5'd16;
   localparam logic [4:0] ModeUpperFirst = 5'd17;
   localparam logic [4:0] ModeSponge     = 5'd18;

   // character codes
   localparam logic [7:0] CharNone       = 8'h00;
   localparam logic [7:0] CharTab        = 8'h09;
   localparam logic [7:0] CharLf         = 8'h0A;
   localparam logic [7:0] CharCr         = 8'h0D;
   localparam logic [7:0] CharSpace      = 8'h20;
   localparam logic [7:0] CharDash       = 8'h2D;
   localparam logic [7:0] CharDot        = 8'h2E;
   localparam logic [7:0] CharSlash      = 8'h2F;
   localparam logic [7:0] CharUnderscore = 8'h5F;
   localparam logic [7:0] CaseOffset     = 8'h20;

   // one queued request: one or two result bytes
   typedef struct packed {
      logic [7:0] first_char;
      logic [7:0] second_char;
      logic       two;
   } tcc_entry_type;

   function automatic logic is_lo(input logic [7:0] c);
      return (c >= 8'h61) && (c <= 8'h7A);
   endfunction

   function automatic logic is_up(input logic [7:0] c);
      return (c >= 8'h41) && (c <= 8'h5A);
   endfunction

   function automatic logic [7:0] to_lo(input logic [7:0] c);
      return is_up(c) ? c + CaseOffset : c;
   endfunction

   function automatic logic [7:0] to_up(input logic [7:0] c);
      return is_lo(c) ? c - CaseOffset : c;
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return (c == CharSpace) || (c == CharTab) || (c == CharCr) || (c == CharLf) ||
             (c == CharDot) || (c == CharUnderscore) || (c == CharSlash) ||
             (c == CharDash);
   endfunction

   // joiner byte of a word mode, none for camel, pascal and the non-word modes
   function automatic logic [7:0] joiner_of(input logic [4:0] m);
      logic [7:0] j;
      unique case (m) inside
         ModeCapital, ModeNo, ModeSentence, ModeTitle: j = CharSpace;
         ModeConstant, ModeSnake:                      j = CharUnderscore;
         ModeDot:                                      j = CharDot;
         ModeHeader, ModeParam:                        j = CharDash;
         ModePath:                                     j = CharSlash;
         default:                                      j = CharNone;
      endcase
      return j;
   endfunction

endpackage

// ===== sv/tcc_front.sv =====
// front part: mode register, string state and classification of each request
module tcc_front import tcc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,
   input  logic          req_tuser,
   input  logic          csr_we,
   input  logic [4:0]    csr_wdata,
   input  logic          q_full,
   output logic          push,
   output tcc_entry_type push_entry
);

   logic [4:0] mode_ff;
   logic       lead_ff, pwl_ff, aws_ff, odd_ff, nee_ff;
   logic       lead_in, pwl_in, aws_in, odd_in, nee_in;
   logic       lead, pwl, aws, odd, nee;
   logic       accept, word, has_out, two, ins, aws_e, nee_e;
   logic [7:0] c, j, o, first;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !q_full;
   assign c          = req_tdata;

   // state seen by this request, cleared on the first byte of a string
   assign lead = req_tuser ? 1'b1 : lead_ff;
   assign pwl  = req_tuser ? 1'b0 : pwl_ff;
   assign aws  = req_tuser ? 1'b1 : aws_ff;
   assign odd  = req_tuser ? 1'b0 : odd_ff;
   assign nee  = req_tuser ? 1'b1 : nee_ff;

   assign word = (mode_ff >= ModeCamel) && (mode_ff <= ModeTitle);
   assign j    = joiner_of(mode_ff);

   // classify the byte and work out its results and the next state
   always_comb begin
      lead_in = lead;
      pwl_in  = pwl;
      aws_in  = aws;
      nee_in  = nee;
      odd_in  = !odd;
      has_out = 1'b0;
      two     = 1'b0;
      ins     = 1'b0;
      aws_e   = aws;
      nee_e   = nee;
      o       = c;
      first   = c;
      if (word) begin
         if (is_sep(c)) begin
            if (!lead) begin
               if (j != CharNone) begin
                  has_out = 1'b1;
                  first   = j;
                  nee_in  = 1'b0;
               end
               aws_in = 1'b1;
            end
            pwl_in = 1'b0;
         end else begin
            // lower-to-upper boundary inserts a joiner
            ins   = (j != CharNone) && pwl && is_up(c);
            aws_e = aws || ins;
            nee_e = nee && !ins;
            o     = to_lo(c);
            unique case (mode_ff) inside
               ModeConstant: o = to_up(c);
               ModeCapital, ModeHeader, ModeTitle, ModePascal: begin
                  if (aws_e) o = to_up(c);
               end
               ModeSentence: begin
                  if (nee_e) o = to_up(c);
               end
               ModeCamel: begin
                  if (!nee_e && aws_e) o = to_up(c);
               end
               default: o = to_lo(c);
            endcase
            has_out = 1'b1;
            two     = ins;
            first   = ins ? j : o;
            lead_in = 1'b0;
            pwl_in  = is_lo(c);
            aws_in  = 1'b0;
            nee_in  = 1'b0;
         end
      end else begin
         unique case (mode_ff)
            ModeSwap:       o = is_lo(c) ? to_up(c) : to_lo(c);
            ModeLower:      o = to_lo(c);
            ModeLowerFirst: o = nee ? to_lo(c) : c;
            ModeUpper:      o = to_up(c);
            ModeUpperFirst: o = nee ? to_up(c) : c;
            ModeSponge:     o = odd ? to_lo(c) : to_up(c);
            default:        o = c;
         endcase
         has_out = 1'b1;
         first   = o;
         nee_in  = 1'b0;
      end
   end

   assign push                   = accept && has_out;
   assign push_entry.first_char  = first;
   assign push_entry.second_char = o;
   assign push_entry.two         = two;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModePass;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   // string state
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= 1'b1;
         pwl_ff  <= 1'b0;
         aws_ff  <= 1'b1;
         odd_ff  <= 1'b0;
         nee_ff  <= 1'b1;
      end else if (accept) begin
         lead_ff <= lead_in;
         pwl_ff  <= pwl_in;
         aws_ff  <= aws_in;
         odd_ff  <= odd_in;
         nee_ff  <= nee_in;
      end
   end

endmodule

// ===== sv/tcc_queue.sv =====
// short queue of classified requests between front and back
module tcc_queue import tcc_pkg::*; #(
   parameter int DEPTH = QueueDepth
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  tcc_entry_type push_entry,
   input  logic          pop,
   output logic          full,
   output logic          valid,
   output tcc_entry_type head
);

   localparam int PtrWidth   = $clog2(DEPTH);
   localparam int CountWidth = $clog2(DEPTH + 1);

   tcc_entry_type              store_ff [DEPTH];
   logic [PtrWidth-1:0]        wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CountWidth-1:0]      count_ff, count_in;

   assign full  = count_ff == CountWidth'(DEPTH);
   assign valid = count_ff != '0;
   assign head  = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== sv/tcc_back.sv =====
// back part: splits queued requests into result bytes in the output register
module tcc_back import tcc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  tcc_entry_type head,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,
   output logic          rsp_tlast
);

   logic       valid_ff, valid_in;
   logic       phase_ff, phase_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       load;

   assign load = !valid_ff || rsp_tready;

   // pick the next byte of the head entry
   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = q_valid;
         if (q_valid) begin
            if (head.two && !phase_ff) begin
               data_in  = head.first_char;
               last_in  = 1'b0;
               phase_in = 1'b1;
            end else begin
               data_in  = phase_ff ? head.second_char : head.first_char;
               last_in  = 1'b1;
               phase_in = 1'b0;
               pop      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== sv/text_case_converter.sv =====
// top level of the streaming ascii case-style converter
// Takes one byte per cycle and rewrites it into the case style held in the mode
// register; a byte yields zero, one or two result bytes, the last one marked by
// rsp_tlast. A request is accepted in the cycle it arrives whenever the queue
// between the classifying front and the output back has room, so the input runs
// at one byte per cycle. The output register drains one byte per cycle while
// rsp_tready allows: a byte that gets an inserted joiner occupies it for both
// its result bytes, and once the queue of QUEUE_DEPTH entries fills, that
// stalls the input. Separators dropped by a word style produce nothing. Reset
// has no clearing pass. Write the mode only while no results are outstanding.
module text_case_converter import tcc_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_char
   input  logic       req_tuser,   // string_start
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_char
   output logic       rsp_tlast,   // last_of_item
   input  logic       csr_we,
   input  logic [4:0] csr_wdata    // case_mode
);

   logic          push, pop, q_full, q_valid;
   tcc_entry_type push_entry, head;

   // classification front
   tcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decoupling queue
   tcc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .valid      (q_valid),
      .head       (head)
   );

   // output back
   tcc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sv/tcc_checker.sv =====
// port-level checker of the case converter and its bind
`include "text_case_converter_macros.svh"

module tcc_checker import tcc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // a stalled result holds
   `TCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")

   // nothing is offered right after reset and the input is open
   `TCC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid && req_tready, "not idle after reset")

   // a byte that is not the last of its request is always a joiner
   `TCC_ASSERT_NOW(a_first_is_joiner, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata == CharSpace || rsp_tdata == CharUnderscore || rsp_tdata == CharDot || rsp_tdata == CharDash || rsp_tdata == CharSlash, "non-final byte is not a joiner")

   // the second byte of a pair follows at once
   `TCC_ASSERT_NEXT(a_pair_follows, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid, "second byte of a pair missing")

endmodule

bind text_case_converter tcc_checker u_checker (.*);
